// ===== design/rfor_pkg.sv =====
`timescale 1ns / 1ps

package rfor_pkg;

  // Canvas geometry: row stride is the maximum width
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int FracBits   = 8;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int CanvasDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = ColW + RowW;
  localparam int SizeW      = 9;
  localparam int CoordW     = 19;
  // working width of the pixel-vs-edge subtractors
  localparam int CalcW      = CoordW + 2;

  localparam logic [7:0] LETTER_FILL    = 8'h52;  // 'R'
  localparam logic [7:0] LETTER_OUTLINE = 8'h72;  // 'r'

  localparam logic [SizeW-1:0] RESET_WIDTH  = SizeW'(256);
  localparam logic [SizeW-1:0] RESET_HEIGHT = SizeW'(256);
  localparam logic [7:0]       RESET_BACKGROUND = 8'd32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_BACKGROUND = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  // request payload, first field in the high bits
  typedef struct packed {
    logic [1:0]               pad;
    logic [RowW-1:0]          read_row;
    logic [ColW-1:0]          read_col;
    logic [7:0]               paint_color;
    logic signed [CoordW-1:0] rect_height;
    logic signed [CoordW-1:0] rect_width;
    logic signed [CoordW-1:0] rect_y;
    logic signed [CoordW-1:0] rect_x;
    logic [7:0]               shape_letter;
    logic [1:0]               opcode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       error_flag;
    logic [7:0] pixel_value;
  } out_item_t;

  // last used column index: 0 counts as 1, large values saturate
  function automatic logic [ColW-1:0] last_col(input logic [SizeW-1:0] reg_val);
    logic [ColW-1:0] res;
    if (reg_val == '0) begin
      res = '0;
    end else if (reg_val >= SizeW'(MaxWidth)) begin
      res = ColW'(MaxWidth - 1);
    end else begin
      res = ColW'(reg_val - SizeW'(1));
    end
    return res;
  endfunction

  function automatic logic [RowW-1:0] last_row(input logic [SizeW-1:0] reg_val);
    logic [RowW-1:0] res;
    if (reg_val == '0) begin
      res = '0;
    end else if (reg_val >= SizeW'(MaxHeight)) begin
      res = RowW'(MaxHeight - 1);
    end else begin
      res = RowW'(reg_val - SizeW'(1));
    end
    return res;
  endfunction

endpackage

// ===== design/rectangle_fill_outline_raster_unit.sv =====
`timescale 1ns / 1ps

// Byte canvas raster engine (filled / outline axis-aligned rectangles).
// Input stream (in_*): one request per transfer; opcode 0 clears the used
//   canvas to the background byte and clears the sticky error, 1 draws a
//   rectangle ('R' filled, 'r' outline), 2 reads one pixel, 3 is a no-op.
// Output stream (out_*): exactly one response per request, in order, with
//   the pixel byte (reads only, else zero) and the sticky error flag.
// Config port (cfg_*): always ready; index 0 width, 1 height, 2 background.
//   Write only while no request is in flight.
// Timing: clear and a valid draw sweep every used pixel, one per cycle,
//   through the single canvas write port. A read inside the used canvas
//   goes through a registered memory read; one outside it, a rejected or
//   ignored draw and a no-op go straight to the response.
//   in_tready is low while a request is being worked on.
// The response sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the next finished response waits in
//   the engine until the register frees up.
// Reset: sizes 256x256, background 32, error clear. The canvas itself is
//   not initialized and holds garbage until cleared or drawn.
module rectangle_fill_outline_raster_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // opcode, shape_letter, rect_x, rect_y, rect_width, rect_height,
  // paint_color, read_col, read_row (low bit up), 2 pad bits
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  rfor_pkg::in_item_t        in_tdata,
  // pixel_value, error_flag (low bit up), 7 pad bits
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output rfor_pkg::out_item_t       out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [rfor_pkg::SizeW-1:0] cfg_data
);

  import rfor_pkg::*;

  localparam logic signed [CalcW-1:0] ONE_C = CalcW'(1 << FracBits);

  // config
  logic [SizeW-1:0] width_r, height_r;
  logic [7:0]       bg_r;

  // control
  state_t state_r, state_nxt;
  logic   err_r, err_nxt;
  logic   out_valid_r, out_valid_nxt;

  // request context
  op_t              op_r;
  logic             filled_r;
  logic [7:0]       fill_r;
  logic [ColW-1:0]  x_r, x_nxt, last_x_r;
  logic [RowW-1:0]  y_r, y_nxt, last_y_r;
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic signed [CalcW-1:0] left_r, right_r, top_r, bottom_r;
  logic [7:0]       pix_r, pix_nxt;
  out_item_t        out_data_r;

  // accepted request decode
  logic       accept;
  logic       draw_ok;
  logic signed [CalcW-1:0] in_x, in_y, in_w, in_h;

  // shared pixel test unit
  logic signed [CalcW-1:0] px, py, dx0, dx1, dy0, dy1;
  logic outside, edge_hit, paint;

  // memory port
  logic       mem_we, mem_re;
  logic [7:0] mem_rdata;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      bg_r     <= RESET_BACKGROUND;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:      width_r  <= cfg_data;
        CFG_HEIGHT:     height_r <= cfg_data;
        CFG_BACKGROUND: bg_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_x = CalcW'(in_tdata.rect_x);
  assign in_y = CalcW'(in_tdata.rect_y);
  assign in_w = CalcW'(in_tdata.rect_width);
  assign in_h = CalcW'(in_tdata.rect_height);
  assign draw_ok = (in_w > 0) && (in_h > 0) &&
                   ((in_tdata.shape_letter == LETTER_FILL) ||
                    (in_tdata.shape_letter == LETTER_OUTLINE));

  // pixel (x, y) scaled to fixed point, checked against the left, right, top and bottom edges
  assign px  = CalcW'({x_r, {FracBits{1'b0}}});
  assign py  = CalcW'({y_r, {FracBits{1'b0}}});
  assign dx0 = px - left_r;
  assign dx1 = right_r - px;
  assign dy0 = py - top_r;
  assign dy1 = bottom_r - py;
  assign outside  = dx0[CalcW-1] | dx1[CalcW-1] | dy0[CalcW-1] | dy1[CalcW-1];
  assign edge_hit = (dx0 < ONE_C) || (dx1 < ONE_C) || (dy0 < ONE_C) || (dy1 < ONE_C);
  assign paint    = (op_r == OP_CLEAR) || (!outside && (edge_hit || filled_r));

  assign mem_we = (state_r == ST_SWEEP) && paint;
  assign mem_re = (state_r == ST_RD_REQ);

  rfor_ram #(
    .Width (8),
    .Depth (CanvasDepth)
  ) u_canvas (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({y_r, x_r}),
    .wdata (fill_r),
    .re    (mem_re),
    .raddr ({row_r, col_r}),
    .rdata (mem_rdata)
  );

  // request context, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_tdata.opcode);
      filled_r <= (in_tdata.shape_letter == LETTER_FILL);
      fill_r   <= (in_tdata.opcode == OP_CLEAR) ? bg_r : in_tdata.paint_color;
      last_x_r <= last_col(width_r);
      last_y_r <= last_row(height_r);
      col_r    <= in_tdata.read_col;
      row_r    <= in_tdata.read_row;
      left_r   <= in_x;
      right_r  <= in_x + in_w;
      top_r    <= in_y;
      bottom_r <= in_y + in_h;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    pix_r <= pix_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= '{pad: '0, error_flag: err_r, pixel_value: pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt   = '0;
          y_nxt   = '0;
          pix_nxt = '0;
          case (in_tdata.opcode)
            OP_CLEAR: state_nxt = ST_SWEEP;
            OP_DRAW: begin
              if (err_r) begin
                state_nxt = ST_DONE;
              end else if (!draw_ok) begin
                err_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            OP_READ: begin
              // out of the used canvas reads as zero
              if (in_tdata.read_col > last_col(width_r) ||
                  in_tdata.read_row > last_row(height_r)) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_RD_REQ;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (x_r == last_x_r) begin
          x_nxt = '0;
          if (y_r == last_y_r) begin
            if (op_r == OP_CLEAR) begin
              err_nxt = 1'b0;
            end
            state_nxt = ST_DONE;
          end else begin
            y_nxt = y_r + RowW'(1);
          end
        end else begin
          x_nxt = x_r + ColW'(1);
        end
      end
      ST_RD_REQ:  state_nxt = ST_RD_DATA;
      ST_RD_DATA: begin
        pix_nxt   = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/rfor_ram.sv =====
`timescale 1ns / 1ps

module rfor_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
